@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int DEPTH        = 16;
  localparam int PRIO_BITS    = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_BITS     = $clog2(DEPTH + 1);

  // Operation codes carried on s_tuser.
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [PRIO_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]     payload;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   insert_en;
    logic   pop_en;
    entry_t entry;
  } cell_cmd_t;

  // Result item, lowest field in the lowest bits.
  typedef struct packed {
    logic [1:0]                   status;
    logic [CNT_BITS-1:0]          count;
    logic [PAYLOAD_BITS-1:0]      head_payload;
    logic signed [PRIO_BITS-1:0]  head_priority;
    logic                         head_valid;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// One cell of the sorted chain: holds a single entry and moves it on insert or pop.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_cmd_t cmd,
  input  wire logic              occupied,
  input  wire logic              left_gt,
  input  wire spq_pkg::entry_t   left_entry,
  input  wire spq_pkg::entry_t   right_entry,
  output spq_pkg::entry_t        entry,
  output spq_pkg::entry_t        entry_next,
  output logic                   gt
);

  // A held entry strictly above the new priority stays in front of it.
  assign gt = occupied && ($signed(entry.prio) > $signed(cmd.entry.prio));

  always_comb begin
    entry_next = entry;
    if (cmd.insert_en) begin
      if (gt) begin
        entry_next = entry;
      end else if (left_gt) begin
        entry_next = cmd.entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (cmd.pop_en) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: chain of cells, count and output buffer.
// Depends on spq_pkg and spq_cell.
`default_nettype none

// A queue of up to DEPTH entries kept sorted with the highest priority at the
// head; an insert lands in front of every entry of lower or equal priority.
// Each input item (insert, pop, clear) yields one result item giving the head
// after the operation, the count and a status. Every cell compares its own
// entry with the new priority at once and shifts towards or away from its
// neighbour as the item is taken, so items are taken back to back unless
// input stalls. A result register with a skid stage behind it keeps input
// flowing while one result waits; input stalls only when both are full.
module sorted_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // priority_req [15:0], payload [47:16]
  input  wire logic [1:0]  s_tuser,   // func [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // head_valid [0], head_priority [16:1],
                                      // head_payload [48:17], count [53:49],
                                      // status [55:54]
);

  localparam int D = spq_pkg::DEPTH;

  logic                          acc_in;
  logic                          take_out;
  logic [spq_pkg::CNT_BITS-1:0]  count;
  logic [spq_pkg::CNT_BITS-1:0]  count_next;
  logic [1:0]                    status_now;
  spq_pkg::cell_cmd_t            cmd;
  spq_pkg::entry_t               cell_entry [D];
  spq_pkg::entry_t               cell_next  [D];
  logic [D-1:0]                  cell_gt;
  spq_pkg::result_t              res;
  spq_pkg::result_t              out_data;
  spq_pkg::result_t              skid_data;
  logic                          out_valid;
  logic                          skid_valid;

  assign s_tready = !skid_valid;
  assign acc_in   = s_tvalid && s_tready;
  assign take_out = out_valid && m_tready;

  always_comb begin
    cmd.insert_en     = 1'b0;
    cmd.pop_en        = 1'b0;
    cmd.entry.prio    = s_tdata[spq_pkg::PRIO_BITS-1:0];
    cmd.entry.payload = s_tdata[spq_pkg::PRIO_BITS +: spq_pkg::PAYLOAD_BITS];
    count_next        = count;
    status_now        = spq_pkg::STATUS_OK;
    case (s_tuser)
      spq_pkg::FUNC_INSERT: begin
        if (count == spq_pkg::CNT_BITS'(D)) begin
          status_now = spq_pkg::STATUS_FULL;
        end else begin
          cmd.insert_en = acc_in;
          count_next    = count + 1'b1;
        end
      end
      spq_pkg::FUNC_POP: begin
        if (count == '0) begin
          status_now = spq_pkg::STATUS_EMPTY;
        end else begin
          cmd.pop_en = acc_in;
          count_next = count - 1'b1;
        end
      end
      spq_pkg::FUNC_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_gt;

    if (i == 0) begin : g_first
      // The head cell takes a new entry whenever its own entry is not above it.
      assign left_gt    = 1'b1;
      assign left_entry = cmd.entry;
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == D - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (spq_pkg::CNT_BITS'(i) < count),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i]),
      .gt          (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc_in) begin
      count <= count_next;
    end
  end

  always_comb begin
    res            = '0;
    res.status     = status_now;
    res.count      = count_next;
    res.head_valid = (count_next != '0);
    if (count_next != '0) begin
      res.head_priority = cell_next[0].prio;
      res.head_payload  = cell_next[0].payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc_in;
      end
    end else if (acc_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (acc_in) begin
        out_data <= res;
      end
    end else if (acc_in) begin
      skid_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// Port-level checks for the sorted priority queue, bound to its top level.
// Depends on spq_pkg and sorted_priority_queue.
`default_nettype none

module spq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);

  spq_pkg::result_t r;
  assign r = m_tdata;

  // A held result item must not change under back-pressure.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result valid or input stalled straight after reset");

  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r.head_valid == (r.count != '0)) &&
                 (r.head_valid || (r.head_priority == '0 && r.head_payload == '0)))
    else $error("head fields disagree with count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == spq_pkg::STATUS_FULL |->
      r.count == spq_pkg::CNT_BITS'(spq_pkg::DEPTH))
    else $error("dropped insert reported on a queue that is not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == spq_pkg::STATUS_EMPTY |-> r.count == '0 && !r.head_valid)
    else $error("empty pop reported on a queue that holds entries");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
